// ----- rtl/core/rfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rfcm_pkg
// Shared constants and helpers for the frame command matcher.
// ----------------------------------------------------------------------------
package rfcm_pkg;

    localparam logic [7:0]  C_START      = 8'h2A;   // '*'
    localparam logic [7:0]  C_CR         = 8'h0D;   // carriage return
    localparam logic [15:0] C_RD_TEXT    = 16'h5244; // "RD", first char high
    localparam logic [15:0] C_RE_TEXT    = 16'h5245; // "RE", first char high
    localparam int          C_ADDR_LEN   = 6;
    localparam int          C_CMD_BASE   = C_ADDR_LEN + 1;
    localparam int          C_RD_LIMIT   = 2;
    localparam int          C_RE_LIMIT   = 3;
    localparam logic [7:0]  C_CNT_FULL   = 8'd2;
    localparam logic [47:0] C_ADDR_RESET = 48'h30325A393939; // "02Z999"

    // One step of a command match counter.
    function automatic logic [7:0] f_cmd_step(
        input logic [7:0] cnt,
        input logic       in_win,
        input logic       hit,
        input logic       past_lim,
        input logic       is_cr
    );
        if (in_win && hit) begin
            return cnt + 8'd1;
        end else if (past_lim && !is_cr) begin
            return 8'd0;
        end else begin
            return cnt;
        end
    endfunction

endpackage

// ----- rtl/core/rs485_frame_command_matcher.sv -----
// ----------------------------------------------------------------------------
// rs485_frame_command_matcher: one received byte per item, taken while idle, not ready during an echo.
// Echo: the first byte is offered after S_FETCH, S_LOOK, S_FETCH, S_LOOK following the CR item,
//   then each byte passes S_OUT (waits for the sink) and S_LOOK, set by the buffer's single read port.
// Reset (sync, active low): hunting for '*', counters zero, buffer reads empty, address 02Z999.
// ----------------------------------------------------------------------------
module rs485_frame_command_matcher #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: station address, first char in bits 47..40
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // echoed bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast    // last_byte
);

    import rfcm_pkg::*;

    localparam int DEPTH = BUFFER_BYTES + 1;
    localparam int AW    = $clog2(DEPTH);
    // position holds up to BUFFER_BYTES+1 before the wrap check
    localparam int PW    = $clog2(BUFFER_BYTES + 2);

    typedef enum logic [1:0] {
        S_IDLE,   // take rx items
        S_FETCH,  // read of r_idx for the echo in flight
        S_LOOK,   // read data for r_idx is valid
        S_OUT     // echo item waits for the sink
    } t_state;

    t_state      r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]  r_rd_cnt, n_rd_cnt;
    logic [7:0]  r_re_cnt, n_re_cnt;
    logic [47:0] r_station, n_station;
    logic [AW-1:0] r_idx, n_idx;
    logic        r_have, n_have;   // r_hold carries a byte not yet sent
    logic        r_fin, n_fin;     // item in the output reg ends the echo
    logic        r_tail, n_tail;   // buffer exhausted, r_hold goes out last
    logic [7:0]  r_hold, n_hold;
    logic        r_tvalid, n_tvalid;
    logic [7:0]  r_tdata, n_tdata;
    logic        r_tlast, n_tlast;

    // frame buffer port
    logic          buf_clr;
    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [7:0]    buf_wdata;
    logic [7:0]    buf_rdata;

    rfcm_frame_buf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (buf_clr),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (r_idx),
        .o_rdata (buf_rdata)
    );

    logic       rx_acc;
    logic [7:0] rx_b;
    logic [7:0] addr_ch;
    logic       in_win;
    logic [7:0] rd_next, re_next;
    logic       last_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign rx_acc        = s_axis_tvalid && s_axis_tready;
    assign rx_b          = s_axis_tdata;
    assign last_idx      = (r_idx == AW'(DEPTH - 1));

    // address character for positions 1..6
    always_comb begin
        case (r_pos)
            PW'(1):  addr_ch = r_station[47:40];
            PW'(2):  addr_ch = r_station[39:32];
            PW'(3):  addr_ch = r_station[31:24];
            PW'(4):  addr_ch = r_station[23:16];
            PW'(5):  addr_ch = r_station[15:8];
            PW'(6):  addr_ch = r_station[7:0];
            default: addr_ch = 8'h00;
        endcase
    end

    // command counters; the two-letter window is positions 7 and 8
    assign in_win  = (r_pos < PW'(C_CMD_BASE + 2));
    assign rd_next = f_cmd_step(r_rd_cnt, in_win,
                                rx_b == (r_pos[0] ? C_RD_TEXT[15:8] : C_RD_TEXT[7:0]),
                                r_pos >= PW'(C_CMD_BASE + C_RD_LIMIT), rx_b == C_CR);
    assign re_next = f_cmd_step(r_re_cnt, in_win,
                                rx_b == (r_pos[0] ? C_RE_TEXT[15:8] : C_RE_TEXT[7:0]),
                                r_pos >= PW'(C_CMD_BASE + C_RE_LIMIT), rx_b == C_CR);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_rd_cnt  = r_rd_cnt;
        n_re_cnt  = r_re_cnt;
        n_station = r_station;
        n_idx     = r_idx;
        n_have    = r_have;
        n_fin     = r_fin;
        n_tail    = r_tail;
        n_hold    = r_hold;
        n_tvalid  = r_tvalid;
        n_tdata   = r_tdata;
        n_tlast   = r_tlast;
        buf_clr   = 1'b0;
        buf_we    = 1'b0;
        buf_waddr = r_pos[AW-1:0];
        buf_wdata = rx_b;

        if (i_cfg_we) begin
            n_station = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (rx_acc) begin
                    if (rx_b == C_START) begin
                        // new frame: empty buffer, '*' at entry 0
                        buf_clr   = 1'b1;
                        buf_we    = 1'b1;
                        buf_waddr = '0;
                        n_rd_cnt  = 8'd0;
                        n_re_cnt  = 8'd0;
                        n_pos     = PW'(1);
                    end else if (r_pos == '0) begin
                        // hunting: byte dropped
                    end else if (r_pos < PW'(C_CMD_BASE)) begin
                        if (rx_b == addr_ch) begin
                            buf_we = 1'b1;
                            n_pos  = r_pos + PW'(1);
                        end else begin
                            n_pos = '0;
                        end
                    end else if (r_pos >= PW'(DEPTH)) begin
                        n_pos = '0;
                    end else begin
                        buf_we   = 1'b1;
                        n_rd_cnt = rd_next;
                        n_re_cnt = re_next;
                        if (rx_b == C_CR) begin
                            // back to address matching without a new '*'
                            n_pos = PW'(1);
                            if (rd_next == C_CNT_FULL || re_next == C_CNT_FULL) begin
                                n_state = S_FETCH;
                                n_idx   = '0;
                                n_have  = 1'b0;
                                n_fin   = 1'b0;
                                n_tail  = 1'b0;
                            end
                        end else if (r_pos + PW'(1) > PW'(BUFFER_BYTES)) begin
                            n_pos = '0;
                        end else begin
                            n_pos = r_pos + PW'(1);
                        end
                    end
                end
            end

            S_FETCH: begin
                n_state = S_LOOK;
            end

            S_LOOK: begin
                // one byte ahead: the held byte is last when the next read is zero
                if (r_have) begin
                    n_tdata  = r_hold;
                    n_tlast  = (buf_rdata == 8'h00);
                    n_tvalid = 1'b1;
                    n_state  = S_OUT;
                    if (buf_rdata == 8'h00) begin
                        n_fin = 1'b1;
                    end else begin
                        n_hold = buf_rdata;
                        if (last_idx) begin
                            n_tail = 1'b1;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                end else if (buf_rdata == 8'h00) begin
                    n_state = S_IDLE;     // zero at entry 0: no echo
                end else begin
                    n_hold = buf_rdata;
                    n_have = 1'b1;
                    if (last_idx) begin
                        n_tdata  = buf_rdata;
                        n_tlast  = 1'b1;
                        n_tvalid = 1'b1;
                        n_fin    = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end

            S_OUT: begin
                if (m_axis_tready) begin
                    n_tvalid = 1'b0;
                    if (r_fin) begin
                        n_state = S_IDLE;
                        n_fin   = 1'b0;
                        n_have  = 1'b0;
                        n_tail  = 1'b0;
                    end else if (r_tail) begin
                        n_tdata  = r_hold;
                        n_tlast  = 1'b1;
                        n_tvalid = 1'b1;
                        n_fin    = 1'b1;
                    end else begin
                        // read of r_idx was issued during the wait
                        n_state = S_LOOK;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_rd_cnt  <= 8'd0;
            r_re_cnt  <= 8'd0;
            r_station <= C_ADDR_RESET;
            r_idx     <= '0;
            r_have    <= 1'b0;
            r_fin     <= 1'b0;
            r_tail    <= 1'b0;
            r_tvalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_rd_cnt  <= n_rd_cnt;
            r_re_cnt  <= n_re_cnt;
            r_station <= n_station;
            r_idx     <= n_idx;
            r_have    <= n_have;
            r_fin     <= n_fin;
            r_tail    <= n_tail;
            r_tvalid  <= n_tvalid;
        end
        r_hold  <= n_hold;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

    // no rx item is taken while an echo item is pending
    a_no_rx_during_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("rx ready while echo item pending");

    // the echo stops at the first zero entry, so a zero byte never goes out
    a_no_zero_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 8'h00))
        else $error("zero byte echoed");

    // a start byte restarts address matching with cleared counters
    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && rx_b == C_START) |=>
            (r_pos == PW'(1) && r_rd_cnt == 8'd0 && r_re_cnt == 8'd0))
        else $error("start byte did not restart frame");

    // an echo begins only after an accepted carriage return
    a_echo_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_FETCH) |-> (rx_acc && rx_b == C_CR))
        else $error("echo started without carriage return");

endmodule

// ----- rtl/core/rfcm_frame_buf.sv -----
// ----------------------------------------------------------------------------
// rfcm_frame_buf
// Frame buffer memory, one write and one registered read port per cycle.
// Per-entry valid bits make a clear instant; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module rfcm_frame_buf #(
    parameter int DEPTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld, n_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;

    // clear first, then mark the written entry
    always_comb begin
        n_vld = i_clr ? '0 : r_vld;
        if (i_we) begin
            n_vld[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule
